### sv/orlb_pkg.sv
`timescale 1ns / 1ps

package orlb_pkg;

  // Default geometry
  localparam int DEPTH_DEFAULT   = 4096;
  localparam int MAX_RUN_DEFAULT = 2048;

  // Fixed field widths
  localparam int LEN_W  = 12;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;

  // Item kinds
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic              load_resp;  // capture a result for the word just accepted
    logic [STAT_W-1:0] status;     // status code of that result
    logic              do_read;    // pop oldest byte
    logic              do_store;   // push input byte, overwrite oldest when full
    logic              start_run;  // begin a new write run
    logic              step_run;   // count one more byte of the current run
  } orlb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;        // nothing unread
    logic run_idle;     // no run bytes still expected
    logic run_dropped;  // current run was rejected
    logic no_fit;       // a run starting now with discard set would be rejected
  } orlb_stat_t;

endpackage

### sv/orlb_ctrl.sv
`timescale 1ns / 1ps

module orlb_ctrl import orlb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic       first_of_write,
  input  orlb_stat_t stat,
  output orlb_cmd_t  cmd,
  output logic       out_valid,
  input  logic       out_ready
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESP);
  assign accept    = in_valid && in_ready;

  // Sequencing: take a word, then hold its result until taken
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_RESP;
      S_RESP: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode the accepted word into datapath commands
  always_comb begin
    cmd = '0;
    cmd.status = ST_OK;
    if (accept) begin
      cmd.load_resp = 1'b1;
      priority if (mode == MODE_READ) begin
        if (stat.empty) cmd.status = ST_EMPTY;
        else cmd.do_read = 1'b1;
      end else if (first_of_write) begin
        cmd.start_run = 1'b1;
        if (stat.no_fit) cmd.status = ST_DROPPED;
        else cmd.do_store = 1'b1;
      end else if (stat.run_idle) begin
        // stray byte outside any run
        cmd.status = ST_DROPPED;
      end else begin
        cmd.step_run = 1'b1;
        if (stat.run_dropped) cmd.status = ST_DROPPED;
        else cmd.do_store = 1'b1;
      end
    end
  end

endmodule

### sv/orlb_dp.sv
`timescale 1ns / 1ps

module orlb_dp import orlb_pkg::*; #(
  parameter int BUFFER_DEPTH = DEPTH_DEFAULT,
  parameter int MAX_RUN      = MAX_RUN_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [LEN_W-1:0]  write_length,
  input  logic              discard_when_full,
  input  orlb_cmd_t         cmd,
  output orlb_stat_t        stat,
  output logic [STAT_W-1:0] status,
  output logic [BYTE_W-1:0] read_byte
);

  localparam int PTR_W = $clog2(BUFFER_DEPTH);
  localparam int OCC_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(BUFFER_DEPTH);
  localparam int RUN_LIM_I = (MAX_RUN < BUFFER_DEPTH - 1) ? MAX_RUN : BUFFER_DEPTH - 1;
  localparam logic [31:0] RUN_LIM = 32'(RUN_LIM_I);
  localparam logic [31:0] DEPTH_W = 32'(BUFFER_DEPTH);

  logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
  logic [PTR_W-1:0]  read_position;
  logic [PTR_W-1:0]  write_position;
  logic [OCC_W-1:0]  occupancy;
  logic [LEN_W-1:0]  run_remaining;
  logic              run_dropped;
  logic [LEN_W-1:0]  len_c;
  logic [31:0]       fill_sum;
  logic [PTR_W-1:0]  rp_inc;
  logic [PTR_W-1:0]  wp_inc;

  // Ring increments with wrap at the last entry
  assign rp_inc = (read_position == LAST_POS) ? '0 : read_position + 1'b1;
  assign wp_inc = (write_position == LAST_POS) ? '0 : write_position + 1'b1;

  // Run length clamp; a zero length still carries one byte
  always_comb begin
    len_c = write_length;
    if (32'(write_length) > RUN_LIM) len_c = RUN_LIM[LEN_W-1:0];
    if (len_c == '0) len_c = LEN_W'(1);
  end

  assign fill_sum = 32'(occupancy) + 32'(len_c);

  assign stat.empty       = (occupancy == '0);
  assign stat.run_idle    = (run_remaining == '0);
  assign stat.run_dropped = run_dropped;
  assign stat.no_fit      = discard_when_full && (fill_sum > DEPTH_W);

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      read_position  <= '0;
      write_position <= '0;
      occupancy      <= '0;
    end else if (cmd.do_read) begin
      read_position <= rp_inc;
      occupancy     <= occupancy - 1'b1;
    end else if (cmd.do_store) begin
      write_position <= wp_inc;
      if (occupancy == FULL_OCC) read_position <= rp_inc;
      else occupancy <= occupancy + 1'b1;
    end
  end

  // Run tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      run_remaining <= '0;
      run_dropped   <= 1'b0;
    end else if (cmd.start_run) begin
      run_remaining <= len_c - 1'b1;
      run_dropped   <= stat.no_fit;
    end else if (cmd.step_run) begin
      run_remaining <= run_remaining - 1'b1;
    end
  end

  // Byte store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.do_store) mem[write_position] <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.do_read) read_byte <= mem[read_position];
    else if (cmd.load_resp) read_byte <= '0;
  end

  // Result status
  always_ff @(posedge clk) begin
    if (cmd.load_resp) status <= cmd.status;
  end

endmodule

### sv/overwriting_log_ring_buffer.sv
`timescale 1ns / 1ps

// Byte ring buffer for a log console. Each input word is a write of one byte
// or a read of the oldest unread byte; every word yields exactly one result
// word. A write run opens with a word that has first_of_write set and carries
// the run length (clamped to MAX_RUN and BUFFER_DEPTH - 1, zero taken as one)
// and the discard flag. A run that would overflow the unread data is rejected
// whole when discard is set (each of its words answers "dropped"), otherwise
// the oldest bytes are overwritten. A non-first write byte with no run open
// is answered "dropped". Reads return the byte or an "empty" status with zero
// data. One word is handled at a time: it is accepted and applied to the
// pointers and the byte store (one write port, one registered read port), its
// result is registered in the output register and held there until taken,
// and no new word is accepted before that.
module overwriting_log_ring_buffer import orlb_pkg::*; #(
  parameter int BUFFER_DEPTH = DEPTH_DEFAULT,
  parameter int MAX_RUN      = MAX_RUN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_byte[7:0], write_length[19:8], zero pad
  input  logic [2:0]  s_tuser,   // mode[0], first_of_write[1], discard_when_full[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // read_byte[7:0]
  output logic [1:0]  m_tuser    // status[1:0]
);

  orlb_cmd_t  cmd;
  orlb_stat_t stat;

  orlb_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .mode           (s_tuser[0]),
    .first_of_write (s_tuser[1]),
    .stat           (stat),
    .cmd            (cmd),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready)
  );

  orlb_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_RUN      (MAX_RUN)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .data_byte         (s_tdata[7:0]),
    .write_length      (s_tdata[19:8]),
    .discard_when_full (s_tuser[2]),
    .cmd               (cmd),
    .stat              (stat),
    .status            (m_tuser),
    .read_byte         (m_tdata)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import orlb_pkg::*;

  localparam int RING_DEPTH  = DEPTH_DEFAULT;
  localparam int RUN_LIMIT   = MAX_RUN_DEFAULT;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 8;

  // One input word, unpacked
  typedef struct {
    logic        mode;
    logic [7:0]  data;
    logic        first;
    logic [11:0] len;
    logic        discard;
  } log_word_t;

  // One result word
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [7:0]        rbyte;
  } log_reply_t;

  // Directed row: word plus an optional hand-typed reply
  typedef struct {
    log_word_t  word;
    bit         typed;
    log_reply_t reply;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // data_byte[7:0], write_length[19:8], zero pad
  logic [2:0]  s_tuser;   // mode[0], first_of_write[1], discard_when_full[2]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // read_byte[7:0]
  logic [1:0]  m_tuser;   // status[1:0]

  // Shadow copy of the ring state
  logic [7:0]  ring_bytes [RING_DEPTH];
  logic [11:0] ring_rd_pos;
  logic [11:0] ring_wr_pos;
  int          ring_fill;
  int          ring_run_left;
  bit          ring_run_rejected;

  log_reply_t    pending_replies[$];
  directed_row_t directed_rows[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int mismatch_count;
  int cycle_count;
  int gen_run_left;

  overwriting_log_ring_buffer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("overwriting_log_ring_buffer regression: fail");
      $finish;
    end
  end

  // Push one byte into the shadow ring; a full ring loses its oldest byte
  task automatic ring_push(input logic [7:0] b);
    ring_bytes[ring_wr_pos] = b;
    ring_wr_pos = ring_wr_pos + 12'd1;
    if (ring_fill >= RING_DEPTH) begin
      ring_rd_pos = ring_rd_pos + 12'd1;
    end else begin
      ring_fill++;
    end
  endtask

  // Apply one accepted word to the shadow ring and return its reply
  task automatic ring_apply(input log_word_t w, output log_reply_t r);
    int run_len;
    r.status = ST_OK;
    r.rbyte  = 8'h00;
    if (w.mode == MODE_READ) begin
      if (ring_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.rbyte = ring_bytes[ring_rd_pos];
        ring_rd_pos = ring_rd_pos + 12'd1;
        ring_fill--;
      end
    end else if (w.first) begin
      run_len = int'(w.len);
      if (run_len > RUN_LIMIT) run_len = RUN_LIMIT;
      if (run_len > RING_DEPTH - 1) run_len = RING_DEPTH - 1;
      if (run_len == 0) run_len = 1;
      ring_run_left     = run_len - 1;
      ring_run_rejected = w.discard && (ring_fill + run_len > RING_DEPTH);
      if (ring_run_rejected) r.status = ST_DROPPED;
      else ring_push(w.data);
    end else if (ring_run_left == 0) begin
      // stray byte outside any run
      r.status = ST_DROPPED;
    end else begin
      ring_run_left--;
      if (ring_run_rejected) r.status = ST_DROPPED;
      else ring_push(w.data);
    end
  endtask

  // Offer one word, wait for the handshake, then record its reply
  task automatic send_word(input log_word_t w, input bit typed, input log_reply_t typed_reply);
    log_reply_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, w.len, w.data};
    s_tuser  <= {w.discard, w.first, w.mode};
    do @(posedge clk); while (!s_tready);
    ring_apply(w, predicted);
    pending_replies.push_back(typed ? typed_reply : predicted);
  endtask

  // Random traffic: mostly well-formed runs with random content, some reads and noise
  task automatic run_phase(input int n_words, input int idle_pct, input int stall_pct,
                           input int read_pct, input int big_pct);
    log_word_t  w;
    log_reply_t unused;
    int         pick;
    int         run_len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    unused = '{ST_OK, 8'h00};
    for (int i = 0; i < n_words; i++) begin
      pick      = $urandom_range(0, 99);
      w.mode    = MODE_WRITE;
      w.data    = 8'($urandom);
      w.first   = 1'b0;
      w.len     = 12'($urandom_range(0, 4095));
      w.discard = 1'($urandom);
      if (pick < read_pct) begin
        // read, other fields left as garbage
        w.mode  = MODE_READ;
        w.first = 1'($urandom);
      end else if (pick < read_pct + 3 || (gen_run_left > 0 && $urandom_range(0, 99) != 0)) begin
        // next byte of the run, or a stray byte when none is open
        if (gen_run_left > 0) gen_run_left--;
      end else begin
        // open a new run, possibly abandoning the current one
        if ($urandom_range(0, 99) < big_pct) run_len = $urandom_range(1500, RUN_LIMIT - 1);
        else if ($urandom_range(0, 9) == 0) run_len = $urandom_range(17, 300);
        else run_len = $urandom_range(1, 16);
        w.first = 1'b1;
        w.len   = 12'(run_len);
        case ($urandom_range(0, 19))
          0: begin
            w.len   = 12'd0;
            run_len = 1;
          end
          1: begin
            w.len   = 12'($urandom_range(RUN_LIMIT, 4095));
            run_len = RUN_LIMIT;
          end
          default: ;
        endcase
        gen_run_left = run_len - 1;
      end
      send_word(w, 1'b0, unused);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    hold_seen = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen++;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    log_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: status %0d byte %02h", m_tuser, m_tdata);
      end else begin
        want = pending_replies.pop_front();
        if (m_tuser !== want.status || m_tdata !== want.rbyte) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d byte %02h, got status %0d byte %02h",
                     want.status, want.rbyte, m_tuser, m_tdata);
        end
      end
    end
  end

  // Main sequence
  initial begin
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    gen_run_left   = 0;
    ring_rd_pos    = '0;
    ring_wr_pos    = '0;
    ring_fill      = 0;
    ring_run_left  = 0;
    ring_run_rejected = 1'b0;
    for (int i = 0; i < RING_DEPTH; i++) ring_bytes[i] = 8'h00;

    // Directed words: empty read, stray byte, zero length, clamped lengths,
    // new run inside a run, read inside a run, garbage fields on reads
    directed_rows.push_back('{'{MODE_READ,  8'h00, 1'b0, 12'd0,    1'b0}, 1'b1, '{ST_EMPTY,   8'h00}});
    directed_rows.push_back('{'{MODE_WRITE, 8'h3C, 1'b0, 12'd0,    1'b0}, 1'b1, '{ST_DROPPED, 8'h00}});
    directed_rows.push_back('{'{MODE_WRITE, 8'h00, 1'b1, 12'd0,    1'b0}, 1'b1, '{ST_OK,      8'h00}});
    directed_rows.push_back('{'{MODE_READ,  8'h00, 1'b0, 12'd0,    1'b0}, 1'b1, '{ST_OK,      8'h00}});
    directed_rows.push_back('{'{MODE_READ,  8'h00, 1'b0, 12'd0,    1'b0}, 1'b1, '{ST_EMPTY,   8'h00}});
    directed_rows.push_back('{'{MODE_WRITE, 8'hFF, 1'b1, 12'd3,    1'b1}, 1'b1, '{ST_OK,      8'h00}});
    directed_rows.push_back('{'{MODE_WRITE, 8'hA5, 1'b0, 12'd0,    1'b0}, 1'b1, '{ST_OK,      8'h00}});
    directed_rows.push_back('{'{MODE_WRITE, 8'h5A, 1'b0, 12'd0,    1'b0}, 1'b1, '{ST_OK,      8'h00}});
    directed_rows.push_back('{'{MODE_WRITE, 8'h11, 1'b0, 12'd0,    1'b0}, 1'b1, '{ST_DROPPED, 8'h00}});
    directed_rows.push_back('{'{MODE_READ,  8'h00, 1'b0, 12'd0,    1'b0}, 1'b1, '{ST_OK,      8'hFF}});
    directed_rows.push_back('{'{MODE_WRITE, 8'h01, 1'b1, 12'hFFF,  1'b0}, 1'b0, '{ST_OK,      8'h00}});
    directed_rows.push_back('{'{MODE_READ,  8'h00, 1'b0, 12'd0,    1'b0}, 1'b0, '{ST_OK,      8'h00}});
    directed_rows.push_back('{'{MODE_WRITE, 8'h02, 1'b0, 12'd0,    1'b0}, 1'b0, '{ST_OK,      8'h00}});
    directed_rows.push_back('{'{MODE_WRITE, 8'h80, 1'b1, 12'd2048, 1'b1}, 1'b0, '{ST_OK,      8'h00}});
    directed_rows.push_back('{'{MODE_WRITE, 8'h7F, 1'b1, 12'd1,    1'b1}, 1'b0, '{ST_OK,      8'h00}});
    directed_rows.push_back('{'{MODE_WRITE, 8'hC3, 1'b0, 12'd0,    1'b0}, 1'b0, '{ST_OK,      8'h00}});
    directed_rows.push_back('{'{MODE_READ,  8'hFF, 1'b1, 12'hFFF,  1'b1}, 1'b0, '{ST_OK,      8'h00}});
    for (int i = 0; i < 5; i++)
      directed_rows.push_back('{'{MODE_READ, 8'h00, 1'b0, 12'd0, 1'b0}, 1'b0, '{ST_OK, 8'h00}});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].reply);

    // Random phases: no idling, sender idle, receiver stalling, both
    run_phase(300,  0,  0, 30, 2);
    run_phase(250, 79,  0, 30, 2);
    run_phase(250,  0, 79, 30, 2);
    run_phase(250, 26, 26, 40, 2);

    // Long receiver hold-off stalls the input, then long runs build up fill
    hold_requests = hold_requests + 1;
    run_phase(600, 0, 0, 3, 40);

    // Drain the stored bytes
    run_phase(250, 10, 10, 60, 5);
    run_phase(100,  0,  0, 90, 0);

    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("overwriting_log_ring_buffer regression: pass");
    end else begin
      $display("overwriting_log_ring_buffer regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
sv/orlb_pkg.sv
sv/orlb_ctrl.sv
sv/orlb_dp.sv
sv/overwriting_log_ring_buffer.sv
test/tb_top.sv
